### rtl/rotation_matrix_to_quaternion_top_macros.svh
// Assertion macros shared by the rotation matrix to quaternion RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`ifndef SYNTH
`define RMQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rmq assertion failed");
`define RMQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rmq assertion failed");
`else
`define RMQ_ASSERT(lbl, clk, rstn, prop)
`define RMQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/rmq_pkg.sv
// Package for the rotation matrix to quaternion block: widths, codes and the
// classified item type. No dependencies.
package rmq_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int RAD_W       = 17;   // radicand, at most 114687
  localparam int S_W         = 16;   // square root, at most 46340
  localparam int NUM_W       = 17;   // signed off-diagonal sums and differences
  localparam int DEN_W       = S_W + 1;
  localparam int QB          = 16;   // quotient bits below the overflow limit
  localparam int REM_W       = DEN_W + 1;
  localparam int N_W         = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int CNT_W       = 2;

  // Component that receives half the root; COMP_W marks the positive-trace case.
  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_Z,
    COMP_W
  } comp_e;

  typedef struct packed {
    comp_e                   hsel;
    logic [RAD_W-1:0]        rad;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } cls_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

endpackage

### rtl/rmq_front.sv
// Front end: accepts an item and classifies it (trace sign, pivot, radicand,
// numerators). Depends on rmq_pkg.
module rmq_front (
  input  logic [8:0][15:0]  m_i,
  input  logic              in_valid_i,
  input  rmq_pkg::qstat_t   qstat_i,
  output logic              push_o,
  output rmq_pkg::cls_t     cls_o
);
  import rmq_pkg::*;

  function automatic logic signed [18:0] sx(logic [15:0] v);
    return signed'({{3{v[15]}}, v});
  endfunction

  assign push_o = in_valid_i && !qstat_i.full;

  always_comb begin : p_cls
    logic signed [18:0] d00, d01, d02, d10, d11, d12, d20, d21, d22;
    logic signed [18:0] tr, one, rads, a0, a1, a2;
    comp_e              sel;
    d00 = sx(m_i[0]); d01 = sx(m_i[1]); d02 = sx(m_i[2]);
    d10 = sx(m_i[3]); d11 = sx(m_i[4]); d12 = sx(m_i[5]);
    d20 = sx(m_i[6]); d21 = sx(m_i[7]); d22 = sx(m_i[8]);
    one = signed'(19'(ONE));
    tr  = d00 + d11 + d22;
    if (tr > 0) begin
      sel  = COMP_W;
      rads = tr + one;
    end else begin
      sel = COMP_X;
      if (d11 > d00) sel = COMP_Y;
      if ((sel == COMP_X && d22 > d00) || (sel == COMP_Y && d22 > d11)) sel = COMP_Z;
      rads = '0;
    end
    unique case (sel)
      COMP_W: begin
        a0 = d12 - d21; a1 = d20 - d02; a2 = d01 - d10;
      end
      COMP_X: begin
        rads = d00 - (d11 + d22) + one;
        a0 = d12 - d21; a1 = d01 + d10; a2 = d02 + d20;
      end
      COMP_Y: begin
        rads = d11 - (d22 + d00) + one;
        a0 = d20 - d02; a1 = d12 + d21; a2 = d10 + d01;
      end
      COMP_Z: begin
        rads = d22 - (d00 + d11) + one;
        a0 = d01 - d10; a1 = d20 + d02; a2 = d21 + d12;
      end
      default: begin
        a0 = '0; a1 = '0; a2 = '0;
      end
    endcase
    // Even a non-rotation input cannot make the radicand negative; this clamp is a guard.
    if (rads < 0) rads = '0;
    cls_o.hsel = sel;
    cls_o.rad  = rads[RAD_W-1:0];
    cls_o.n0   = a0[NUM_W-1:0];
    cls_o.n1   = a1[NUM_W-1:0];
    cls_o.n2   = a2[NUM_W-1:0];
  end

endmodule

### rtl/rmq_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
// Depends on rmq_pkg and the assertion macro header.
`include "rotation_matrix_to_quaternion_top_macros.svh"
module rmq_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rmq_pkg::cls_t    data_i,
  input  logic             pop_i,
  output rmq_pkg::cls_t    data_o,
  output rmq_pkg::qstat_t  qstat_o
);
  import rmq_pkg::*;

  cls_t             ent_q [QUEUE_DEPTH];
  logic             wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CNT_W'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= data_i;
  end

  assign data_o           = ent_q[rd_ptr_q];
  assign qstat_o.full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign qstat_o.nonempty = (cnt_q != '0);

  `RMQ_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(QUEUE_DEPTH))
  `RMQ_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop_i |-> cnt_q != '0)
  `RMQ_ASSERT(a_push_room, clk_i, rst_ni, push_i |-> cnt_q != CNT_W'(QUEUE_DEPTH))

endmodule

### rtl/rmq_back.sv
// Back end: pipelined square root, pipelined rounding division of the three
// numerators, saturation and the output register. Depends on rmq_pkg.
`include "rotation_matrix_to_quaternion_top_macros.svh"
module rmq_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rmq_pkg::cls_t    data_i,
  input  rmq_pkg::qstat_t  qstat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [15:0]      quat_x_o,
  output logic [15:0]      quat_y_o,
  output logic [15:0]      quat_z_o,
  output logic [15:0]      quat_w_o
);
  import rmq_pkg::*;

  typedef struct packed {
    logic           valid;
    logic [N_W-1:0] n;
    logic [N_W-1:0] res;
    cls_t           c;
  } sq_t;

  typedef struct packed {
    logic             neg;
    logic             zero;
    logic             ovf;
    logic [DEN_W-1:0] den;
    logic [QB-1:0]    nlo;
    logic [REM_W-1:0] rem;
    logic [QB-1:0]    q;
  } dl_t;

  typedef struct packed {
    logic            valid;
    comp_e           hsel;
    logic [S_W-2:0]  half;
    dl_t [2:0]       ln;
  } dv_t;

  sq_t         sq_q [S_W+1];
  dv_t         dv_q [QB+1];
  dv_t         dv0_d;
  logic        en;
  logic        out_valid_q;
  logic [15:0] qx_q, qy_q, qz_q, qw_q;
  logic [15:0] qx_d, qy_d, qz_d, qw_d;

  function automatic sq_t sq_step(sq_t a, logic [N_W-1:0] bitv);
    sq_t            b;
    logic [N_W-1:0] t;
    b = a;
    t = a.res + bitv;
    if (a.n >= t) begin
      b.n   = a.n - t;
      b.res = (a.res >> 1) + bitv;
    end else begin
      b.res = a.res >> 1;
    end
    return b;
  endfunction

  function automatic dl_t lane_prep(logic signed [NUM_W-1:0] v, logic [S_W-1:0] s);
    dl_t              l;
    logic [NUM_W-1:0] mag;
    logic [N_W-1:0]   num;
    l.neg  = v[NUM_W-1];
    mag    = l.neg ? NUM_W'(-v) : NUM_W'(v);
    num    = N_W'({mag, FRAC_BITS'(0)}) + N_W'(s);
    l.den  = {s, 1'b0};
    l.zero = (s == '0);
    l.ovf  = {1'b0, num} >= {l.den, QB'(0)};
    l.rem  = REM_W'(num[N_W-1:QB]);
    l.nlo  = num[QB-1:0];
    l.q    = '0;
    return l;
  endfunction

  function automatic dl_t lane_step(dl_t a);
    dl_t              b;
    logic [REM_W-1:0] r;
    b = a;
    r = {a.rem[REM_W-2:0], a.nlo[QB-1]};
    b.nlo = {a.nlo[QB-2:0], 1'b0};
    if (r >= REM_W'(a.den)) begin
      b.rem = r - REM_W'(a.den);
      b.q   = {a.q[QB-2:0], 1'b1};
    end else begin
      b.rem = r;
      b.q   = {a.q[QB-2:0], 1'b0};
    end
    return b;
  endfunction

  function automatic logic [15:0] lane_sat(dl_t l);
    logic [15:0] r;
    if (l.zero) begin
      r = '0;
    end else if (l.ovf) begin
      r = l.neg ? 16'h8000 : 16'h7fff;
    end else if (l.neg) begin
      r = (l.q > 16'h8000) ? 16'h8000 : 16'(-l.q);
    end else begin
      r = (l.q > 16'h7fff) ? 16'h7fff : l.q;
    end
    return r;
  endfunction

  // The whole back end moves together unless the output holds an item that
  // the receiver stalls.
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && qstat_i.nonempty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q[0] <= '0;
    end else if (en) begin
      sq_q[0].valid <= qstat_i.nonempty;
      sq_q[0].n     <= N_W'({data_i.rad, FRAC_BITS'(0)});
      sq_q[0].res   <= '0;
      sq_q[0].c     <= data_i;
    end
  end

  for (genvar k = 0; k < S_W; k++) begin : g_sq
    localparam logic [N_W-1:0] BitV = 32'h4000_0000 >> (2 * k);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[k+1] <= '0;
      end else if (en) begin
        sq_q[k+1] <= sq_step(sq_q[k], BitV);
      end
    end
  end

  always_comb begin : p_prep
    logic [S_W-1:0] s;
    s           = sq_q[S_W].res[S_W-1:0];
    dv0_d.valid = sq_q[S_W].valid;
    dv0_d.hsel  = sq_q[S_W].c.hsel;
    dv0_d.half  = s[S_W-1:1];
    dv0_d.ln[0] = lane_prep(sq_q[S_W].c.n0, s);
    dv0_d.ln[1] = lane_prep(sq_q[S_W].c.n1, s);
    dv0_d.ln[2] = lane_prep(sq_q[S_W].c.n2, s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= '0;
    end else if (en) begin
      dv_q[0] <= dv0_d;
    end
  end

  for (genvar t = 0; t < QB; t++) begin : g_dv
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[t+1] <= '0;
      end else if (en) begin
        dv_q[t+1].valid <= dv_q[t].valid;
        dv_q[t+1].hsel  <= dv_q[t].hsel;
        dv_q[t+1].half  <= dv_q[t].half;
        dv_q[t+1].ln[0] <= lane_step(dv_q[t].ln[0]);
        dv_q[t+1].ln[1] <= lane_step(dv_q[t].ln[1]);
        dv_q[t+1].ln[2] <= lane_step(dv_q[t].ln[2]);
      end
    end
  end

  always_comb begin : p_map
    logic [15:0] r0, r1, r2, h;
    r0 = lane_sat(dv_q[QB].ln[0]);
    r1 = lane_sat(dv_q[QB].ln[1]);
    r2 = lane_sat(dv_q[QB].ln[2]);
    h  = {1'b0, dv_q[QB].half};
    unique case (dv_q[QB].hsel)
      COMP_W: begin qx_d = r0; qy_d = r1; qz_d = r2; qw_d = h;  end
      COMP_X: begin qx_d = h;  qy_d = r1; qz_d = r2; qw_d = r0; end
      COMP_Y: begin qx_d = r2; qy_d = h;  qz_d = r1; qw_d = r0; end
      COMP_Z: begin qx_d = r1; qy_d = r2; qz_d = h;  qw_d = r0; end
      default: begin qx_d = '0; qy_d = '0; qz_d = '0; qw_d = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_q[QB].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && dv_q[QB].valid) begin
      qx_q <= qx_d;
      qy_q <= qy_d;
      qz_q <= qz_d;
      qw_q <= qw_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign quat_x_o    = qx_q;
  assign quat_y_o    = qy_q;
  assign quat_z_o    = qz_q;
  assign quat_w_o    = qw_q;

  `RMQ_ASSERT(a_pos_root, clk_i, rst_ni, (dv_q[0].valid && dv_q[0].hsel == COMP_W) |-> dv_q[0].half != '0)
  `RMQ_ASSERT(a_rem_below, clk_i, rst_ni, (dv_q[0].valid && !dv_q[0].ln[0].ovf && !dv_q[0].ln[0].zero) |-> dv_q[0].ln[0].rem < REM_W'(dv_q[0].ln[0].den))
  `RMQ_ASSERT_NEXT(a_hold_stall, clk_i, rst_ni, !en, out_valid_q && $stable(dv_q[0]))

endmodule

### rtl/rotation_matrix_to_quaternion_top.sv
// Top level of the rotation matrix to quaternion converter.
// Depends on rmq_pkg, rmq_front, rmq_queue and rmq_back.
//
// Usage: present the nine Q2.14 matrix entries m00_i..m22_i with in_valid_i;
// an item is taken at a clock edge where in_valid_i is high and in_stall_o low.
// The quaternion leaves on quat_x_o..quat_w_o with out_valid_o and is taken
// at an edge where out_valid_o is high and out_stall_i low.
// After acceptance an item passes the queue, the square root input register,
// sixteen square root stages (one result bit each), one setup stage for the
// divisions, sixteen restoring division stages (one quotient bit each) and
// the output register. Throughput is one item per cycle unless the receiver
// stalls; division and square root pipelines set the latency, not the rate.
// A two-entry queue sits between the classifier and the arithmetic pipeline.
// When the receiver stalls a waiting result, the whole pipeline holds; the
// queue keeps taking items until both entries are full, then in_stall_o rises.
// Reset empties the queue and clears every valid bit; no results are pending.
module rotation_matrix_to_quaternion_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] m00_i,
  input  logic [15:0] m01_i,
  input  logic [15:0] m02_i,
  input  logic [15:0] m10_i,
  input  logic [15:0] m11_i,
  input  logic [15:0] m12_i,
  input  logic [15:0] m20_i,
  input  logic [15:0] m21_i,
  input  logic [15:0] m22_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] quat_x_o,
  output logic [15:0] quat_y_o,
  output logic [15:0] quat_z_o,
  output logic [15:0] quat_w_o
);
  import rmq_pkg::*;

  logic [8:0][15:0] m;
  logic             push, pop;
  cls_t             cls_in, cls_head;
  qstat_t           qstat;

  assign m[0] = m00_i;
  assign m[1] = m01_i;
  assign m[2] = m02_i;
  assign m[3] = m10_i;
  assign m[4] = m11_i;
  assign m[5] = m12_i;
  assign m[6] = m20_i;
  assign m[7] = m21_i;
  assign m[8] = m22_i;

  // The stall depends only on the queue fill, never on in_valid_i.
  assign in_stall_o = qstat.full;

  rmq_front u_front (
    .m_i        (m),
    .in_valid_i (in_valid_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .cls_o      (cls_in)
  );

  rmq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .pop_i   (pop),
    .data_o  (cls_head),
    .qstat_o (qstat)
  );

  rmq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_i      (cls_head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .quat_x_o    (quat_x_o),
    .quat_y_o    (quat_y_o),
    .quat_z_o    (quat_z_o),
    .quat_w_o    (quat_w_o)
  );

endmodule
